// ----- design/lzt_pkg.sv -----
// Shared types, constants and helpers for the lazy-delete keyed table.
// No dependencies; used by lzt_store, lzt_seq and lazy_delete_keyed_table.
package lzt_pkg;

   localparam int DEPTH     = 64;
   localparam int KEY_BITS  = 32;
   localparam int INFO_BITS = 32;
   localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int CAP_BITS  = 7;
   localparam int SLOT_BITS = 6;
   localparam int STAT_BITS = 3;
   localparam int MODE_BITS = 2;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

   // Byte address of the capacity_limit register on the register port.
   localparam logic [2:0] CAP_ADDR = 3'd0;

   localparam logic [MODE_BITS-1:0] MODE_FIND   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_ERASE  = 2'd2;

   localparam logic [STAT_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_EXISTS    = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic                 busy;
      logic [KEY_BITS-1:0]  key;
      logic [INFO_BITS-1:0] info;
   } entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
      logic [IDX_BITS-1:0] rd_addr;
   } mem_req_type;

   // A limit of zero behaves as one, and one above the depth as the depth.
   function automatic logic [CNT_BITS-1:0] eff_capacity(input logic [CAP_BITS-1:0] c);
      logic [CNT_BITS-1:0] r;
      if (c == '0) begin
         r = CNT_BITS'(1);
      end else if (int'(c) > DEPTH) begin
         r = CNT_BITS'(DEPTH);
      end else begin
         r = CNT_BITS'(c);
      end
      return r;
   endfunction

   function automatic logic [SLOT_BITS-1:0] to_slot(input logic [IDX_BITS-1:0] i);
      return SLOT_BITS'(i);
   endfunction

endpackage

// ----- design/lazy_delete_keyed_table.sv -----
// Keyed table with lazy deletion. A find or erase scans the entries one per cycle through
// the single read port of the entry memory. An insert that finds the table at capacity
// adds a compaction walk over the used entries. One request is in flight at a time; the
// next is taken once the word is in the output register. Synchronous active-high reset
// empties the table and sets the limit to 64; the entry memory itself is not cleared,
// since only slots below the fill count are read.
module lazy_delete_keyed_table (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lzt_pkg::MODE_BITS-1:0]     req_mode,
   input  logic [lzt_pkg::KEY_BITS-1:0]      req_key,
   input  logic signed [lzt_pkg::INFO_BITS-1:0] req_info,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lzt_pkg::STAT_BITS-1:0]     rsp_status,
   output logic [lzt_pkg::SLOT_BITS-1:0]     rsp_slot_index,
   // Register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [2:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   // The only register, capacity_limit, lives at byte address zero. Writes to any
   // other address are dropped, and reads there return zero.
   logic [lzt_pkg::CAP_BITS-1:0] cap_ff, cap_in;
   logic                         cap_sel;

   assign cap_sel    = (csr_paddr == lzt_pkg::CAP_ADDR);
   assign csr_pready = 1'b1;

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && cap_sel) begin
         cap_in = csr_pwdata[lzt_pkg::CAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lzt_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign csr_prdata = cap_sel ? {{(32 - lzt_pkg::CAP_BITS){1'b0}}, cap_ff} : '0;

   // The sequencer owns the request flow; the store holds key, info and busy mark
   // together in one word so an entry moves in a single write during compaction.
   lzt_pkg::mem_req_type mem_req;
   lzt_pkg::entry_type   rd_data;

   lzt_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .capacity_limit (cap_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .req_info       (req_info),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   lzt_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// ----- design/lzt_store.sv -----
// Entry memory of the keyed table: one write port and one registered read port.
// Depends on lzt_pkg for the entry and request types.
module lzt_store (
   input  logic                 clock,
   input  lzt_pkg::mem_req_type mem_req,
   output lzt_pkg::entry_type   rd_data
);

   lzt_pkg::entry_type mem_ff [lzt_pkg::DEPTH];
   lzt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lzt_seq.sv -----
// Request sequencer: one key compare unit reused over the entries for the scan.
// Depends on lzt_pkg; drives the entry memory in lzt_store.
module lzt_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lzt_pkg::CAP_BITS-1:0]      capacity_limit,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lzt_pkg::MODE_BITS-1:0]     req_mode,
   input  logic [lzt_pkg::KEY_BITS-1:0]      req_key,
   input  logic [lzt_pkg::INFO_BITS-1:0]     req_info,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lzt_pkg::STAT_BITS-1:0]     rsp_status,
   output logic [lzt_pkg::SLOT_BITS-1:0]     rsp_slot_index,
   output lzt_pkg::mem_req_type              mem_req,
   input  lzt_pkg::entry_type                rd_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_CPACT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [lzt_pkg::MODE_BITS-1:0]    mode_ff, mode_in;
   logic [lzt_pkg::KEY_BITS-1:0]     key_ff, key_in;
   logic [lzt_pkg::INFO_BITS-1:0]    info_ff, info_in;
   logic [lzt_pkg::CNT_BITS-1:0]     ptr_ff, ptr_in;
   logic [lzt_pkg::CNT_BITS-1:0]     wr_ff, wr_in;
   logic [lzt_pkg::CNT_BITS-1:0]     used_ff, used_in;
   logic                             pend_ff, pend_in;
   logic [lzt_pkg::IDX_BITS-1:0]     pend_idx_ff, pend_idx_in;
   logic [lzt_pkg::STAT_BITS-1:0]    res_status_ff, res_status_in;
   logic [lzt_pkg::SLOT_BITS-1:0]    res_slot_ff, res_slot_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lzt_pkg::STAT_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [lzt_pkg::SLOT_BITS-1:0]    rsp_slot_ff, rsp_slot_in;

   logic [lzt_pkg::CNT_BITS-1:0]     cap;
   logic                             hit;
   logic                             more;

   assign cap  = lzt_pkg::eff_capacity(capacity_limit);
   assign hit  = pend_ff && rd_data.busy && (rd_data.key == key_ff) && (key_ff != '0);
   assign more = (ptr_ff < used_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      info_in       = info_ff;
      ptr_in        = ptr_ff;
      wr_in         = wr_ff;
      used_in       = used_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;

      mem_req         = '0;
      mem_req.rd_addr = ptr_ff[lzt_pkg::IDX_BITS-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in     = req_mode;
               key_in      = req_key;
               info_in     = req_info;
               ptr_in      = '0;
               wr_in       = '0;
               pend_in     = 1'b0;
               res_slot_in = '0;
               case (req_mode)
                  lzt_pkg::MODE_FIND, lzt_pkg::MODE_INSERT: begin
                     state_in = S_SCAN;
                  end
                  lzt_pkg::MODE_ERASE: begin
                     if (used_ff == '0) begin
                        res_status_in = lzt_pkg::ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     res_status_in = lzt_pkg::ST_OK;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (hit) begin
               state_in = S_DONE;
               case (mode_ff)
                  lzt_pkg::MODE_FIND: begin
                     res_status_in = lzt_pkg::ST_OK;
                     res_slot_in   = lzt_pkg::to_slot(pend_idx_ff);
                  end
                  lzt_pkg::MODE_INSERT: begin
                     res_status_in = lzt_pkg::ST_EXISTS;
                  end
                  default: begin
                     // Erase only drops the busy mark; the slot stays until compaction.
                     mem_req.wr_en        = 1'b1;
                     mem_req.wr_addr      = pend_idx_ff;
                     mem_req.wr_data      = rd_data;
                     mem_req.wr_data.busy = 1'b0;
                     res_status_in        = lzt_pkg::ST_OK;
                  end
               endcase
            end else if (more) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[lzt_pkg::IDX_BITS-1:0];
               ptr_in      = ptr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (mode_ff == lzt_pkg::MODE_INSERT) begin
                  if (used_ff >= cap) begin
                     ptr_in   = '0;
                     wr_in    = '0;
                     state_in = S_CPACT;
                  end else begin
                     mem_req.wr_en        = 1'b1;
                     mem_req.wr_addr      = used_ff[lzt_pkg::IDX_BITS-1:0];
                     mem_req.wr_data.busy = 1'b1;
                     mem_req.wr_data.key  = key_ff;
                     mem_req.wr_data.info = info_ff;
                     used_in              = used_ff + 1'b1;
                     res_status_in        = lzt_pkg::ST_OK;
                     state_in             = S_DONE;
                  end
               end else begin
                  res_status_in = lzt_pkg::ST_NOT_FOUND;
                  state_in      = S_DONE;
               end
            end
         end

         S_CPACT: begin
            if (pend_ff && rd_data.busy) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = wr_ff[lzt_pkg::IDX_BITS-1:0];
               mem_req.wr_data = rd_data;
               wr_in           = wr_ff + 1'b1;
            end
            if (more) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[lzt_pkg::IDX_BITS-1:0];
               ptr_in      = ptr_ff + 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               // All busy entries now sit below wr_ff.
               state_in = S_DONE;
               if (wr_ff >= cap) begin
                  used_in       = wr_ff;
                  res_status_in = lzt_pkg::ST_FULL;
               end else begin
                  mem_req.wr_en        = 1'b1;
                  mem_req.wr_addr      = wr_ff[lzt_pkg::IDX_BITS-1:0];
                  mem_req.wr_data.busy = 1'b1;
                  mem_req.wr_data.key  = key_ff;
                  mem_req.wr_data.info = info_ff;
                  used_in              = wr_ff + 1'b1;
                  res_status_in        = lzt_pkg::ST_OK;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      info_ff       <= info_in;
      ptr_ff        <= ptr_in;
      wr_ff         <= wr_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule
